// ===== rtl/shd_pkg.sv =====
// Shared types and constants for the SHA-1 / HMAC digest block.
`default_nettype none
package shd_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic KIND_KEY = 1'b0;

  // Key byte count once more than 64 key bytes have arrived
  localparam logic [6:0] KCNT_LONG = 7'd65;

  // Byte source selected by the controller for the absorb step
  localparam logic [2:0] SRC_IN    = 3'd0;
  localparam logic [2:0] SRC_PAD80 = 3'd1;
  localparam logic [2:0] SRC_ZERO  = 3'd2;
  localparam logic [2:0] SRC_LEN   = 3'd3;
  localparam logic [2:0] SRC_IPAD  = 3'd4;
  localparam logic [2:0] SRC_OPAD  = 3'd5;
  localparam logic [2:0] SRC_INNER = 3'd6;

  typedef struct packed {
    logic       absorb;     // place one byte into the block
    logic       count_len;  // add eight to the bit length
    logic [2:0] src;
    logic [5:0] idx;        // key index / length byte / inner byte index
    logic       eng_reset;  // chain to IV, fill and length cleared
    logic       key_clear;  // key store cleared
    logic       key_write;  // store input byte at key_count
    logic       key_fold;   // key store <= chain value, zero padded
    logic       save_inner; // inner digest <= chain value
    logic       round_go;   // run one compression round
    logic       chain_add;  // chain += work registers
    logic       work_load;  // work registers <= chain
    logic [6:0] round;
  } shd_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [6:0] key_count;
  } shd_stat_t;
endpackage
`default_nettype wire

// ===== rtl/shd_datapath.sv =====
// Datapath: key store, block buffer, message schedule and SHA-1 round logic.
`default_nettype none
module shd_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire shd_pkg::shd_cmd_t cmd,
  input  wire logic [7:0]       in_byte,
  output shd_pkg::shd_stat_t    stat,
  output logic [159:0]          digest
);
  import shd_pkg::*;

  logic [31:0] chain_r [5];
  logic [31:0] wk_r [5];
  logic [31:0] w_r [16];
  logic [31:0] key_r [16];   // key bytes, big-endian within each word
  logic [31:0] key_nxt [16];
  logic [159:0] inner_r;
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [6:0]  kcnt_r;

  logic [7:0]  b;
  logic [31:0] f, k, t, wnew;
  logic [1:0]  sh;
  logic [159:0] cv;
  logic [5:0]  fill_eff;
  logic [63:0] len_eff;
  logic [6:0]  kcnt_eff;

  assign cv = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
  assign digest = cv;
  assign stat = {fill_r, kcnt_r};

  // A restart and the first byte may share a cycle
  assign fill_eff = cmd.eng_reset ? 6'd0 : fill_r;
  assign len_eff = cmd.eng_reset ? 64'd0 : len_r;
  assign kcnt_eff = cmd.key_clear ? 7'd0 : kcnt_r;

  // Byte selection for the absorb path
  always_comb begin
    case (cmd.src)
      SRC_IN:    b = in_byte;
      SRC_PAD80: b = 8'h80;
      SRC_ZERO:  b = 8'h00;
      SRC_LEN:   b = len_r[8'(7 - cmd.idx[2:0]) * 8 +: 8];
      SRC_IPAD:  b = key_r[cmd.idx[5:2]][8'(3 - cmd.idx[1:0]) * 8 +: 8] ^ IPAD;
      SRC_OPAD:  b = key_r[cmd.idx[5:2]][8'(3 - cmd.idx[1:0]) * 8 +: 8] ^ OPAD;
      SRC_INNER: b = inner_r[8'(19 - cmd.idx[4:0]) * 8 +: 8];
      default:   b = 8'h00;
    endcase
  end

  // One round: the schedule is a 16-word shift line, w_r[0] is w[i]
  always_comb begin
    if (cmd.round < 7'd20) begin
      f = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]); k = K0;
    end else if (cmd.round < 7'd40) begin
      f = wk_r[1] ^ wk_r[2] ^ wk_r[3]; k = K1;
    end else if (cmd.round < 7'd60) begin
      f = (wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]); k = K2;
    end else begin
      f = wk_r[1] ^ wk_r[2] ^ wk_r[3]; k = K3;
    end
    t = {wk_r[0][26:0], wk_r[0][31:27]} + f + wk_r[4] + k + w_r[0];
    wnew = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wnew = {wnew[30:0], wnew[31]};
    sh = fill_eff[1:0];
  end

  // Key store update: clear, fold of a hashed long key, or one key byte
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      key_nxt[i] = cmd.key_clear ? 32'h0 : key_r[i];
      if (cmd.key_fold) key_nxt[i] = 32'h0;
      if (cmd.key_write && !kcnt_eff[6] && kcnt_eff[5:2] == 4'(i))
        key_nxt[i][8'(3 - kcnt_eff[1:0]) * 8 +: 8] = in_byte;
    end
    if (cmd.key_fold)
      for (int j = 0; j < 5; j++) key_nxt[j] = chain_r[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= H0; chain_r[1] <= H1; chain_r[2] <= H2;
      chain_r[3] <= H3; chain_r[4] <= H4;
      fill_r <= '0; len_r <= '0; kcnt_r <= '0;
      for (int i = 0; i < 16; i++) key_r[i] <= '0;
    end else begin
      if (cmd.eng_reset) begin
        chain_r[0] <= H0; chain_r[1] <= H1; chain_r[2] <= H2;
        chain_r[3] <= H3; chain_r[4] <= H4;
      end else if (cmd.chain_add) begin
        for (int i = 0; i < 5; i++) chain_r[i] <= chain_r[i] + wk_r[i];
      end
      if (cmd.absorb) begin
        if (sh == 2'd0) w_r[fill_eff[5:2]] <= {b, 24'h0};
        else w_r[fill_eff[5:2]][8'(3 - sh) * 8 +: 8] <= b;
        fill_r <= fill_eff + 6'd1;
        len_r <= cmd.count_len ? len_eff + 64'd8 : len_eff;
      end else if (cmd.eng_reset) begin
        fill_r <= '0; len_r <= '0;
      end
      if (cmd.key_write) kcnt_r <= kcnt_eff[6] ? KCNT_LONG : kcnt_eff + 7'd1;
      else if (cmd.key_clear) kcnt_r <= '0;
      for (int i = 0; i < 16; i++) key_r[i] <= key_nxt[i];
      if (cmd.save_inner) inner_r <= cv;
      if (cmd.work_load) for (int i = 0; i < 5; i++) wk_r[i] <= chain_r[i];
      if (cmd.round_go) begin
        wk_r[4] <= wk_r[3]; wk_r[3] <= wk_r[2];
        wk_r[2] <= {wk_r[1][1:0], wk_r[1][31:2]};
        wk_r[1] <= wk_r[0]; wk_r[0] <= t;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
        w_r[15] <= wnew;
      end
    end
  end

  property p_nolen;
    @(posedge clk) disable iff (!rst_n) cmd.round_go |-> !cmd.absorb;
  endproperty
  a_nolen: assert property (p_nolen) else $error("absorb during rounds");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.work_load |-> fill_r == 6'd63) else $error("compress with partial block");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.absorb && cmd.count_len && !cmd.eng_reset |=> len_r == $past(len_r) + 64'd8)
    else $error("length not advanced");
endmodule
`default_nettype wire

// ===== rtl/shd_ctrl.sv =====
// Controller: sequences key, message, padding, HMAC passes and compression.
`default_nettype none
module shd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_kind,
  input  wire logic              in_present,
  input  wire logic              in_last,
  input  wire shd_pkg::shd_stat_t stat,
  output shd_pkg::shd_cmd_t      cmd,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [2:0]             out_idx
);
  import shd_pkg::*;

  localparam logic [3:0] S_WAIT  = 4'd0;
  localparam logic [3:0] S_ROUND = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_P80   = 4'd3;
  localparam logic [3:0] S_PZ    = 4'd4;
  localparam logic [3:0] S_PLEN  = 4'd5;
  localparam logic [3:0] S_KFOLD = 4'd6;
  localparam logic [3:0] S_IPAD  = 4'd7;
  localparam logic [3:0] S_SAVE  = 4'd8;
  localparam logic [3:0] S_OPAD  = 4'd9;
  localparam logic [3:0] S_INNER = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // Finish purposes: what happens when padding completes
  localparam logic [1:0] FIN_KEY = 2'd0;
  localparam logic [1:0] FIN_INNER = 2'd1;
  localparam logic [1:0] FIN_OUT = 2'd2;

  // Phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_KEY = 2'd1;
  localparam logic [1:0] PH_MSG = 2'd2;

  logic [3:0] st_r, st_nxt, ret_r, ret_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] fin_r, fin_nxt, ph_r, ph_nxt;
  logic       hmac_r, hmac_nxt, pend_r, pend_nxt;
  logic [2:0] oi_r, oi_nxt;
  logic       acc, full;

  assign in_tready = (st_r == S_WAIT);
  assign acc = in_tvalid && in_tready;
  assign full = (stat.fill == 6'd63);
  assign out_tvalid = (st_r == S_OUT);
  assign out_idx = oi_r;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; rnd_nxt = rnd_r; cnt_nxt = cnt_r;
    fin_nxt = fin_r; ph_nxt = ph_r; hmac_nxt = hmac_r; pend_nxt = pend_r;
    oi_nxt = oi_r;
    cmd = '0;
    cmd.round = rnd_r;
    cmd.idx = cnt_r;
    case (st_r)
      S_WAIT: begin
        if (acc) begin
          if (in_kind == KIND_KEY) begin
            // a key beat outside key loading starts a fresh key
            if (ph_r != PH_KEY) begin
              cmd.eng_reset = 1'b1; cmd.key_clear = 1'b1; hmac_nxt = 1'b0;
            end
            ph_nxt = PH_KEY;
            pend_nxt = in_last;
            fin_nxt = FIN_KEY;
            if (in_present) begin
              cmd.absorb = 1'b1; cmd.count_len = 1'b1; cmd.src = SRC_IN;
              cmd.key_write = 1'b1;
            end
            if (in_present && full && ph_r == PH_KEY) begin
              st_nxt = S_ROUND; ret_nxt = in_last ? S_KFOLD : S_WAIT;
              cmd.work_load = 1'b1; rnd_nxt = '0;
            end else if (in_last) st_nxt = S_KFOLD;
          end else begin
            // a message beat during key loading drops the key
            if (ph_r == PH_KEY) begin
              cmd.eng_reset = 1'b1; cmd.key_clear = 1'b1; hmac_nxt = 1'b0;
            end
            ph_nxt = PH_MSG;
            fin_nxt = (hmac_r && ph_r != PH_KEY) ? FIN_INNER : FIN_OUT;
            if (in_present) begin
              cmd.absorb = 1'b1; cmd.count_len = 1'b1; cmd.src = SRC_IN;
            end
            if (in_present && full && ph_r != PH_KEY) begin
              st_nxt = S_ROUND; ret_nxt = in_last ? S_P80 : S_WAIT;
              cmd.work_load = 1'b1; rnd_nxt = '0;
            end else if (in_last) st_nxt = S_P80;
          end
        end
      end
      S_ROUND: begin
        cmd.round_go = 1'b1; rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) st_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1; st_nxt = ret_r;
      end
      S_P80: begin
        cmd.absorb = 1'b1; cmd.src = SRC_PAD80; cnt_nxt = '0;
        st_nxt = (stat.fill == 6'd55) ? S_PLEN : S_PZ;
        if (full) begin
          cmd.work_load = 1'b1; rnd_nxt = '0; ret_nxt = S_PZ; st_nxt = S_ROUND;
        end
      end
      S_PZ: begin
        if (stat.fill == 6'd56) st_nxt = S_PLEN;
        else begin
          cmd.absorb = 1'b1; cmd.src = SRC_ZERO;
          if (full) begin
            cmd.work_load = 1'b1; rnd_nxt = '0; ret_nxt = S_PZ; st_nxt = S_ROUND;
          end
        end
        cnt_nxt = '0;
      end
      S_PLEN: begin
        cmd.absorb = 1'b1; cmd.src = SRC_LEN; cnt_nxt = cnt_r + 6'd1;
        if (full) begin
          cmd.work_load = 1'b1; rnd_nxt = '0; st_nxt = S_ROUND; cnt_nxt = '0;
          case (fin_r)
            FIN_KEY:   ret_nxt = S_KFOLD;
            FIN_INNER: ret_nxt = S_SAVE;
            default:   ret_nxt = S_OUT;
          endcase
          oi_nxt = '0;
        end
      end
      // Key finished: a long key is padded and hashed first, then folded;
      // the engine restarts with the ipad block
      S_KFOLD: begin
        if (stat.key_count == KCNT_LONG && pend_r) begin
          fin_nxt = FIN_KEY; st_nxt = S_P80;
        end else begin
          if (stat.key_count == KCNT_LONG) cmd.key_fold = 1'b1;
          cmd.eng_reset = 1'b1; cnt_nxt = '0; st_nxt = S_IPAD;
        end
        pend_nxt = 1'b0;
      end
      S_IPAD: begin
        cmd.absorb = 1'b1; cmd.count_len = 1'b1; cmd.src = SRC_IPAD;
        cnt_nxt = cnt_r + 6'd1;
        if (full) begin
          cmd.work_load = 1'b1; rnd_nxt = '0; st_nxt = S_ROUND; ret_nxt = S_WAIT;
          hmac_nxt = 1'b1; ph_nxt = PH_IDLE;
        end
      end
      S_SAVE: begin
        cmd.save_inner = 1'b1; cmd.eng_reset = 1'b1; cnt_nxt = '0; st_nxt = S_OPAD;
      end
      S_OPAD: begin
        cmd.absorb = 1'b1; cmd.count_len = 1'b1; cmd.src = SRC_OPAD;
        cnt_nxt = cnt_r + 6'd1;
        if (full) begin
          cmd.work_load = 1'b1; rnd_nxt = '0; st_nxt = S_ROUND; ret_nxt = S_INNER;
          cnt_nxt = '0;
        end
      end
      S_INNER: begin
        cmd.absorb = 1'b1; cmd.count_len = 1'b1; cmd.src = SRC_INNER;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd19) begin st_nxt = S_P80; fin_nxt = FIN_OUT; end
      end
      S_OUT: begin
        if (out_tready) begin
          oi_nxt = oi_r + 3'd1;
          if (oi_r == 3'd4) begin
            st_nxt = S_WAIT; cmd.eng_reset = 1'b1; cmd.key_clear = 1'b1;
            hmac_nxt = 1'b0; ph_nxt = PH_IDLE;
          end
        end
      end
      default: st_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_WAIT; ret_r <= S_WAIT; rnd_r <= '0; cnt_r <= '0; fin_r <= FIN_OUT;
      ph_r <= PH_IDLE; hmac_r <= 1'b0; pend_r <= 1'b0; oi_r <= '0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; rnd_r <= rnd_nxt; cnt_r <= cnt_nxt;
      fin_r <= fin_nxt; ph_r <= ph_nxt; hmac_r <= hmac_nxt; pend_r <= pend_nxt;
      oi_r <= oi_nxt;
    end
  end

  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROUND |-> rnd_r < 7'd80) else $error("round overrun");
  a_oi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> oi_r < 3'd5) else $error("digest index overrun");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input open while digest pending");
endmodule
`default_nettype wire

// ===== rtl/sha1_hmac_digest.sv =====
// Top level of the streaming SHA-1 / HMAC-SHA1 digest block.
// A byte beat is taken while the controller waits for input; the beat that
// completes a 64-byte block also starts the shared round unit, which stalls
// the input through the rounds and the chain fold. A message end pads one
// byte per cycle, pausing while a full block is compressed, followed by one or
// two compressions; with HMAC the 64-byte opad block and its compression, then
// the 20-byte inner digest and its padding follow. A key end absorbs the
// 64-byte ipad block and runs a compression; a key over 64 bytes is first
// padded and hashed the same way. The five digest words then leave one per
// beat. Input stays stalled throughout.
`default_nettype none
module sha1_hmac_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // data_byte[7:0], byte_present[8], zero
  input  wire logic        in_tuser,  // kind
  input  wire logic        in_tlast,  // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // digest_word[31:0], word_index[34:32], zero
  output logic             out_tlast  // last_word
);
  import shd_pkg::*;

  shd_cmd_t     cmd;
  shd_stat_t    stat;
  logic [159:0] digest;
  logic [2:0]   idx;

  shd_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_kind(in_tuser), .in_present(in_tdata[8]), .in_last(in_tlast),
    .stat, .cmd, .out_tvalid, .out_tready, .out_idx(idx)
  );

  shd_datapath u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_tdata[7:0]), .stat, .digest
  );

  assign out_tdata = {5'd0, idx, digest[8'(4 - idx) * 32 +: 32]};
  assign out_tlast = (idx == 3'd4);
endmodule
`default_nettype wire

// ===== tb/sv/shd_checker.sv =====
// Checker for the SHA-1 / HMAC digest block: models the hash and compares digest beats.
module shd_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending
);
  import shd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_MSG} phase_e;
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_beat_t;

  logic [31:0] chain [5];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [7:0]  key_bytes [64];
  int          key_cnt;
  bit          key_over;
  bit          hmac_on;
  phase_e      phase;
  digest_beat_t digest_q[$];

  assign pending = digest_q.size();

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one 80-round compression of the block buffer into the chain
  task automatic compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic eng_restart();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    fill = 0;
    bit_len = 0;
  endtask

  // place a byte without counting it in the length
  task automatic place(logic [7:0] v);
    if (fill[1:0] == 0) blk[fill[5:2]] = {v, 24'h0};
    else blk[fill[5:2]] |= 32'(v) << (24 - 8 * fill[1:0]);
    fill++;
    if (fill == 0) compress();
  endtask

  task automatic take(logic [7:0] v);
    place(v);
    bit_len += 8;
  endtask

  task automatic pad_out(output logic [31:0] dg [5]);
    logic [63:0] len;
    len = bit_len;
    place(8'h80);
    while (fill != 56) place(8'h00);
    for (int i = 0; i < 8; i++) place(len[63 - 8*i -: 8]);
    dg = chain;
  endtask

  task automatic clear_all();
    eng_restart();
    foreach (key_bytes[i]) key_bytes[i] = 0;
    key_cnt = 0;
    key_over = 0;
    hmac_on = 0;
    phase = PH_IDLE;
  endtask

  task automatic key_finish();
    logic [31:0] dg [5];
    if (key_over) begin
      pad_out(dg);
      foreach (key_bytes[i]) key_bytes[i] = 0;
      for (int i = 0; i < 20; i++) key_bytes[i] = dg[i >> 2][31 - 8*(i % 4) -: 8];
    end
    eng_restart();
    for (int i = 0; i < 64; i++) take(key_bytes[i] ^ IPAD);
    hmac_on = 1;
    phase = PH_IDLE;
  endtask

  // predict the digest words caused by one input beat
  task automatic predict_beat(logic kind, logic [7:0] v, logic present, logic fin);
    logic [31:0] dg [5];
    logic [31:0] inner [5];
    if (kind == KIND_KEY) begin
      if (phase != PH_KEY) begin
        clear_all();
        phase = PH_KEY;
      end
      if (present) begin
        take(v);
        if (key_cnt < 64) key_bytes[key_cnt++] = v;
        else key_over = 1;
      end
      if (fin) key_finish();
    end else begin
      if (phase == PH_KEY) clear_all();
      phase = PH_MSG;
      if (present) take(v);
      if (fin) begin
        pad_out(dg);
        if (hmac_on) begin
          inner = dg;
          eng_restart();
          for (int i = 0; i < 64; i++) take(key_bytes[i] ^ OPAD);
          for (int i = 0; i < 20; i++) take(inner[i >> 2][31 - 8*(i % 4) -: 8]);
          pad_out(dg);
        end
        for (int i = 0; i < 5; i++) digest_q.push_back('{dg[i], 3'(i), i == 4});
        clear_all();
      end
    end
  endtask

  initial begin
    fail_count = 0;
    clear_all();
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (rst_n && in_tvalid && in_tready)
      predict_beat(in_tuser, in_tdata[7:0], in_tdata[8], in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest beat %h", out_tdata);
        fail_count++;
      end else begin
        exp_b = digest_q.pop_front();
        if (out_tdata[31:0] !== exp_b.word) begin
          $error("digest_word: expected %h, got %h", exp_b.word, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[34:32] !== exp_b.index) begin
          $error("word_index: expected %0d, got %0d", exp_b.index, out_tdata[34:32]);
          fail_count++;
        end
        if (out_tlast !== exp_b.final_word) begin
          $error("last_word: expected %b, got %b", exp_b.final_word, out_tlast);
          fail_count++;
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the SHA-1 / HMAC digest block: stimulus, back-pressure and verdict.
module tb_top;
  import shd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // data_byte[7:0], byte_present[8], zero
  logic        in_tuser;   // kind
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // digest_word[31:0], word_index[34:32], zero
  logic        out_tlast;  // last_word
  int          fail_count;
  int          pending;
  bit          calm;       // no idling on either side
  bit          hold_off;   // long receiver stall
  bit          hold_req;   // stimulus asks for the long stall

  sha1_hmac_digest i_dut (.*);

  shd_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("sha1_hmac_digest: mismatch");
    $finish;
  end

  // receiver: random stalls, one long hold-off, a calm stretch
  initial begin
    out_tready = 0;
    @(negedge clk);
    while (1) begin
      @(negedge clk);
      out_tready <= hold_off ? 1'b0 : (calm || $urandom_range(99) >= 36);
    end
  end

  // long hold-off, counted here once the stimulus asks for it
  initial begin
    hold_off = 0;
    hold_req = 0;
    wait (hold_req);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  // one input beat; random gap before it unless calm
  task automatic send(logic kind, logic [7:0] v, logic present, logic fin);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {7'h0, present, v};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_run(logic kind, int len);
    if (len == 0) send(kind, 8'h00, 0, 1);
    for (int i = 0; i < len; i++)
      if (i == len - 1 && $urandom_range(3) == 0) begin
        send(kind, 8'($urandom), 1, 0);
        send(kind, 8'($urandom), 0, 1);
      end else send(kind, 8'($urandom), 1, i == len - 1);
  endtask

  initial begin
    int n;
    int klen;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0; in_tlast = 0;
    calm = 0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: empty message, extreme bytes, empty key, key cut by message
    send(1, 8'h00, 0, 1);
    send(1, 8'hFF, 1, 0); send(1, 8'h00, 1, 1);
    send(KIND_KEY, 8'h00, 0, 1); send(1, 8'hA5, 1, 1);
    send(KIND_KEY, 8'hFF, 1, 0); send(KIND_KEY, 8'h5A, 1, 0);
    send(1, 8'h11, 1, 1);
    send(KIND_KEY, 8'h01, 1, 1); send(1, 8'h00, 0, 0);
    send(KIND_KEY, 8'h7E, 1, 1); send(1, 8'h80, 1, 1);
    // long key gets hashed down
    send_run(KIND_KEY, 70); send_run(1, 3);
    // long hold-off with the sender pushing: digests wait and the input stalls
    hold_req = 1;
    send_run(1, 2); send_run(1, 4); send_run(1, 1);
    // random: mostly well-formed key+message pairs
    n = 0;
    while (n < 255) begin
      calm = (n > 150 && n < 200);
      case ($urandom_range(9))
        0: begin
          send(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)); n++;
        end
        1, 2, 3: begin
          klen = $urandom_range(8); send_run(1, klen); n += klen + 1;
        end
        default: begin
          klen = ($urandom_range(9) == 0) ? $urandom_range(60, 75) : $urandom_range(6);
          send_run(KIND_KEY, klen); n += klen + 1;
          klen = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(8);
          send_run(1, klen); n += klen + 1;
        end
      endcase
    end
    send(1, 8'h00, 0, 1);
    in_tvalid <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("sha1_hmac_digest: match");
    else $display("sha1_hmac_digest: mismatch");
    $finish;
  end
endmodule
